### sv/tlpac_pkg.sv
package tlpac_pkg;

    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] ZERO_COUNT_MAX = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_BAND_LOW    = 3'd0,
        CFG_HIGH_BAND_HIGH   = 3'd1,
        CFG_LOW_BAND_LOW     = 3'd2,
        CFG_LOW_BAND_HIGH    = 3'd3,
        CFG_INLET_STOP_LEVEL = 3'd4,
        CFG_ALARM_HIGH_LEVEL = 3'd5,
        CFG_ALARM_LOW_LEVEL  = 3'd6,
        CFG_ZERO_RUN_LIMIT   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] high_band_low;
        logic [LEVEL_W-1:0] high_band_high;
        logic [LEVEL_W-1:0] low_band_low;
        logic [LEVEL_W-1:0] low_band_high;
        logic [LEVEL_W-1:0] inlet_stop_level;
        logic [LEVEL_W-1:0] alarm_high_level;
        logic [LEVEL_W-1:0] alarm_low_level;
        logic [COUNT_W-1:0] zero_run_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        high_band_low:    16'd1200,
        high_band_high:   16'd1400,
        low_band_low:     16'd300,
        low_band_high:    16'd400,
        inlet_stop_level: 16'd500,
        alarm_high_level: 16'd1400,
        alarm_low_level:  16'd200,
        zero_run_limit:   4'd10
    };

    typedef struct packed {
        logic               inlet_on;
        logic               outlet_on;
        logic               alarm_on;
        logic               reset_latch;
        logic [COUNT_W-1:0] zero_run_count;
    } t_state;

    localparam t_state STATE_RESET = '{
        inlet_on:       1'b0,
        outlet_on:      1'b0,
        alarm_on:       1'b0,
        reset_latch:    1'b0,
        zero_run_count: '0
    };

endpackage

### sv/tlpac_in_if.sv
interface tlpac_in_if;
    import tlpac_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic               reset_button;
    logic               outlet_button;

    modport source (output valid, output level, output reset_button, output outlet_button,
                    input ready);
    modport sink (input valid, input level, input reset_button, input outlet_button,
                  output ready);
endinterface

### sv/tlpac_out_if.sv
interface tlpac_out_if;
    logic valid;
    logic ready;
    logic inlet_pump;
    logic outlet_pump;
    logic alarm;
    logic reset_pending;

    modport source (output valid, output inlet_pump, output outlet_pump, output alarm,
                    output reset_pending, input ready);
    modport sink (input valid, input inlet_pump, input outlet_pump, input alarm,
                  input reset_pending, output ready);
endinterface

### sv/tank_level_pump_alarm_control.sv
// Tank level controller: each item is one level reading with the alarm reset and manual
// outlet buttons, and gives one result with the inlet pump, outlet pump, alarm and pending
// reset drives after that reading. An item is taken in every cycle unless o_out.ready stalls
// the result; the state update on the input register sets the result register. The user must
// write thresholds through the configuration port only while no item is in flight; the block
// does not enforce it. Out-of-range values behave as plain 16-bit unsigned compares.
module tank_level_pump_alarm_control (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tlpac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tlpac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tlpac_in_if.sink                          i_in,
    tlpac_out_if.source                       o_out
);
    import tlpac_pkg::*;

    t_cfg               r_cfg;
    t_state             r_state;
    t_state             n_state;
    logic               r_in_valid;
    logic [LEVEL_W-1:0] r_level;
    logic               r_reset_button;
    logic               r_outlet_button;
    logic               r_out_valid;
    logic               r_inlet_pump;
    logic               r_outlet_pump;
    logic               r_alarm;
    logic               r_reset_pending;
    logic               adv;

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HIGH_BAND_LOW:    r_cfg.high_band_low    <= i_cfg_data;
                CFG_HIGH_BAND_HIGH:   r_cfg.high_band_high   <= i_cfg_data;
                CFG_LOW_BAND_LOW:     r_cfg.low_band_low     <= i_cfg_data;
                CFG_LOW_BAND_HIGH:    r_cfg.low_band_high    <= i_cfg_data;
                CFG_INLET_STOP_LEVEL: r_cfg.inlet_stop_level <= i_cfg_data;
                CFG_ALARM_HIGH_LEVEL: r_cfg.alarm_high_level <= i_cfg_data;
                CFG_ALARM_LOW_LEVEL:  r_cfg.alarm_low_level  <= i_cfg_data;
                CFG_ZERO_RUN_LIMIT:   r_cfg.zero_run_limit   <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_level         <= i_in.level;
            r_reset_button  <= i_in.reset_button;
            r_outlet_button <= i_in.outlet_button;
        end
    end

    tlpac_step u_step (
        .i_cfg           (r_cfg),
        .i_state         (r_state),
        .i_level         (r_level),
        .i_reset_button  (r_reset_button),
        .i_outlet_button (r_outlet_button),
        .o_next          (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_inlet_pump    <= n_state.inlet_on;
            r_outlet_pump   <= n_state.outlet_on;
            r_alarm         <= n_state.alarm_on;
            r_reset_pending <= n_state.reset_latch;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.inlet_pump    = r_inlet_pump;
    assign o_out.outlet_pump   = r_outlet_pump;
    assign o_out.alarm         = r_alarm;
    assign o_out.reset_pending = r_reset_pending;

    a_alarm_stops_pumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.alarm_on |-> (!r_state.inlet_on && !r_state.outlet_on))
        else $error("pump running while alarm on");

    a_one_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state.inlet_on && r_state.outlet_on))
        else $error("both pumps running");

    a_nonzero_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_level != '0)) |=> (r_state.zero_run_count == '0))
        else $error("zero run count not cleared");

    a_result_follows_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (r_alarm == r_state.alarm_on) && (r_reset_pending == r_state.reset_latch))
        else $error("result does not match state");

endmodule

### sv/tlpac_step.sv
module tlpac_step (
    input  tlpac_pkg::t_cfg                  i_cfg,
    input  tlpac_pkg::t_state                i_state,
    input  logic [tlpac_pkg::LEVEL_W-1:0]    i_level,
    input  logic                             i_reset_button,
    input  logic                             i_outlet_button,
    output tlpac_pkg::t_state                o_next
);
    import tlpac_pkg::*;

    logic latch;
    logic trip;
    logic in_high_band;
    logic in_low_band;
    logic in_clear_band;
    logic level_zero;

    assign level_zero    = (i_level == '0);
    assign in_high_band  = (i_level >= i_cfg.high_band_low) && (i_level <= i_cfg.high_band_high);
    assign in_low_band   = (i_level >= i_cfg.low_band_low) && (i_level <= i_cfg.low_band_high);
    assign in_clear_band = (i_level >= i_cfg.low_band_low) && (i_level <= i_cfg.high_band_low);
    assign latch         = i_state.reset_latch | i_reset_button;

    always_comb begin
        o_next             = i_state;
        o_next.reset_latch = latch;
        trip               = 1'b0;
        if (i_state.alarm_on && latch) begin
            o_next.alarm_on = 1'b0;
        end
        if (level_zero) begin
            if (i_state.zero_run_count != ZERO_COUNT_MAX) begin
                o_next.zero_run_count = i_state.zero_run_count + 1'b1;
            end
            if ((o_next.zero_run_count >= i_cfg.zero_run_limit) && !i_state.alarm_on
                    && !latch) begin
                trip = 1'b1;
            end
        end else begin
            o_next.zero_run_count = '0;
            // at most one pump action per item
            if (!i_state.inlet_on && !i_state.outlet_on && !i_state.alarm_on) begin
                if (in_high_band) begin
                    o_next.inlet_on = 1'b1;
                end else if (in_low_band || i_outlet_button) begin
                    o_next.outlet_on = 1'b1;
                end
            end else if (i_state.inlet_on && (i_level <= i_cfg.inlet_stop_level)) begin
                o_next.inlet_on = 1'b0;
            end else if ((i_state.outlet_on && (i_level >= i_cfg.high_band_low))
                    || i_outlet_button) begin
                o_next.outlet_on = 1'b0;
            end
            if (!i_state.alarm_on && !latch) begin
                if ((i_level >= i_cfg.alarm_high_level) || (i_level <= i_cfg.alarm_low_level)) begin
                    trip = 1'b1;
                end
            end else if (in_clear_band) begin
                o_next.alarm_on    = 1'b0;
                o_next.reset_latch = 1'b0;
            end
        end
        if (trip) begin
            o_next.alarm_on  = 1'b1;
            o_next.inlet_on  = 1'b0;
            o_next.outlet_on = 1'b0;
        end
    end
endmodule
